// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/trmt_pkg.sv
// ----------------------------------------------------------------------------
// trmt_pkg
// shared types and constants of the ternary rule match table
// ----------------------------------------------------------------------------
`default_nettype none

package trmt_pkg;

  localparam int RULE_SLOTS_DEF = 64;
  localparam int COND_WIDTH_DEF = 32;

  localparam int DATA_W    = 32;
  localparam int LEN_IN_W  = 6;
  localparam int LIMIT_W   = 7;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  typedef struct packed {
    logic                op;
    logic [DATA_W-1:0]   cond_value;
    logic [DATA_W-1:0]   cond_care;
    logic [LEN_IN_W-1:0] cond_length;
    logic [DATA_W-1:0]   key_bits;
    logic [LEN_IN_W-1:0] key_length;
    logic [LIMIT_W-1:0]  match_limit;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] matched_index;
    logic                 hit;
    logic                 accepted;
    logic [CNT_OUT_W-1:0] match_count;
    logic                 last;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/trmt_stream_if.sv
// ----------------------------------------------------------------------------
// trmt_stream_if
// valid/ready channel carrying one item per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface trmt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/core/trmt_ram.sv
// ----------------------------------------------------------------------------
// trmt_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module trmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/core/ternary_rule_match_table.sv
// ----------------------------------------------------------------------------
// ternary_rule_match_table
// table of ternary rules with append and in-order match scan
// ----------------------------------------------------------------------------
// in_i carries one item per handshake: op selects add rule or match key.
// out_o carries the result items; every input item ends with one result
// that has last set.
// add: the rule is written at index rule_count and one result is sent once
// the output register frees (accepted clear, nothing stored when table full).
// match: rules are read from the rule ram in index order, one per cycle unless
// the scan stalls; each matching index up to match_limit goes out as one
// result, the final one carrying the count.
// no match gives a single result with hit clear.
// one item is worked on at a time; in_i is ready only while no item is open.
// results pass through an output register, and when the receiver stalls the
// scan holds its place until that register frees up.
// reset empties the table at once (rule count to zero); ram contents are not
// cleared, entries at or above the rule count are never read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ternary_rule_match_table #(
  parameter int RULE_SLOTS = trmt_pkg::RULE_SLOTS_DEF,
  parameter int COND_WIDTH = trmt_pkg::COND_WIDTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  trmt_stream_if.sink   in_i,
  trmt_stream_if.source out_o
);

  localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CNT_W = $clog2(RULE_SLOTS + 1);
  localparam int SW    = (COND_WIDTH < trmt_pkg::DATA_W) ? COND_WIDTH : trmt_pkg::DATA_W;
  localparam int LEN_W = $clog2(COND_WIDTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SW-1:0]    care;
    logic [SW-1:0]    value;
  } rule_t;

  logic [1:0]                     state_q, state_d;
  logic [CNT_W-1:0]               rule_count_q, rule_count_d;
  logic [CNT_W-1:0]               scan_addr_q, scan_addr_d;
  logic                           eval_q, eval_d;
  logic [IDX_W-1:0]               eval_idx_q, eval_idx_d;
  logic                           have_held_q, have_held_d;
  logic [IDX_W-1:0]               held_q, held_d;
  logic [CNT_W-1:0]               found_q, found_d;
  logic                           out_valid_q, out_valid_d;
  trmt_pkg::out_item_t            out_q, out_d;
  rule_t                          wr_rule_q;
  logic [SW-1:0]                  key_q, kmask_q;
  logic [LEN_W-1:0]               klen_q;
  logic [trmt_pkg::LIMIT_W-1:0]   limit_q;

  logic                           in_fire;
  logic [LEN_W-1:0]               cond_len_c, key_len_c;
  logic [SW-1:0]                  kmask_c;
  rule_t                          rd_rule;
  logic                           out_free, table_full;
  logic                           rule_hit, stall, rd_en, wr_en;
  logic                           add_push, mid_push, final_push;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign table_full  = (rule_count_q == CNT_W'(RULE_SLOTS));

  always_comb begin
    if (int'(in_i.payload.cond_length) > COND_WIDTH) begin
      cond_len_c = LEN_W'(COND_WIDTH);
    end else begin
      cond_len_c = LEN_W'(in_i.payload.cond_length);
    end
    if (int'(in_i.payload.key_length) > COND_WIDTH) begin
      key_len_c = LEN_W'(COND_WIDTH);
    end else begin
      key_len_c = LEN_W'(in_i.payload.key_length);
    end
    for (int j = 0; j < SW; j++) begin
      kmask_c[j] = (j < int'(key_len_c));
    end
  end

  // compare of the rule currently at the ram output
  assign rule_hit = eval_q && (rd_rule.len >= klen_q)
                    && (((rd_rule.value ^ key_q) & rd_rule.care & kmask_q) == '0)
                    && (trmt_pkg::LIMIT_W'(found_q) < limit_q);
  assign stall      = rule_hit && have_held_q && !out_free;
  assign rd_en      = (state_q == ST_SCAN) && (scan_addr_q < rule_count_q) && !stall;
  assign add_push   = (state_q == ST_ADD) && out_free;
  assign mid_push   = rule_hit && have_held_q && !stall;
  assign final_push = (state_q == ST_DONE) && out_free;
  assign wr_en      = add_push && !table_full;

  trmt_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (RULE_SLOTS)
  ) u_rule_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (rule_count_q[IDX_W-1:0]),
    .wr_data_i (wr_rule_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_addr_q[IDX_W-1:0]),
    .rd_data_o (rd_rule)
  );

  always_comb begin
    state_d      = state_q;
    rule_count_d = rule_count_q;
    scan_addr_d  = scan_addr_q;
    eval_d       = eval_q;
    eval_idx_d   = eval_idx_q;
    have_held_d  = have_held_q;
    held_d       = held_q;
    found_d      = found_q;
    out_d        = out_q;
    out_valid_d  = out_o.ready ? 1'b0 : out_valid_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          scan_addr_d = '0;
          eval_d      = 1'b0;
          have_held_d = 1'b0;
          found_d     = '0;
          state_d     = (in_i.payload.op == trmt_pkg::OP_MATCH) ? ST_SCAN : ST_ADD;
        end
      end
      ST_ADD: begin
        if (add_push) begin
          out_valid_d         = 1'b1;
          out_d.matched_index = table_full ? '0
                                : trmt_pkg::IDX_OUT_W'(rule_count_q[IDX_W-1:0]);
          out_d.hit           = 1'b0;
          out_d.accepted      = !table_full;
          out_d.match_count   = '0;
          out_d.last          = 1'b1;
          if (!table_full) begin
            rule_count_d = rule_count_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          eval_d     = rd_en;
          eval_idx_d = scan_addr_q[IDX_W-1:0];
          if (rd_en) begin
            scan_addr_d = scan_addr_q + CNT_W'(1);
          end
          if (rule_hit) begin
            held_d      = eval_idx_q;
            have_held_d = 1'b1;
            found_d     = found_q + CNT_W'(1);
          end
        end
        // an earlier match is released once a later one shows it is not last
        if (mid_push) begin
          out_valid_d         = 1'b1;
          out_d.matched_index = trmt_pkg::IDX_OUT_W'(held_q);
          out_d.hit           = 1'b1;
          out_d.accepted      = 1'b0;
          out_d.match_count   = '0;
          out_d.last          = 1'b0;
        end
        if (!eval_q && (scan_addr_q >= rule_count_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (final_push) begin
          out_valid_d         = 1'b1;
          out_d.matched_index = have_held_q ? trmt_pkg::IDX_OUT_W'(held_q) : '0;
          out_d.hit           = have_held_q;
          out_d.accepted      = 1'b0;
          out_d.match_count   = trmt_pkg::CNT_OUT_W'(found_q);
          out_d.last          = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rule_count_q <= '0;
      scan_addr_q  <= '0;
      eval_q       <= 1'b0;
      have_held_q  <= 1'b0;
      found_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rule_count_q <= rule_count_d;
      scan_addr_q  <= scan_addr_d;
      eval_q       <= eval_d;
      have_held_q  <= have_held_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q <= eval_idx_d;
    held_q     <= held_d;
    out_q      <= out_d;
    if (in_fire) begin
      wr_rule_q.value <= in_i.payload.cond_value[SW-1:0];
      wr_rule_q.care  <= in_i.payload.cond_care[SW-1:0];
      wr_rule_q.len   <= cond_len_c;
      key_q           <= in_i.payload.key_bits[SW-1:0];
      kmask_q         <= kmask_c;
      klen_q          <= key_len_c;
      limit_q         <= in_i.payload.match_limit;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, rule_count_q > CNT_W'(RULE_SLOTS), "rule count past table size")
  `ASSERT_NEVER(a_found_bound, clk_i, rst_ni, trmt_pkg::LIMIT_W'(found_q) > limit_q && state_q != ST_IDLE, "matches past limit")
  `ASSERT_CHK(a_eval_scan, clk_i, rst_ni, eval_q |-> (state_q == ST_SCAN), "ram read outside scan")
  `ASSERT_CHK(a_no_overwrite, clk_i, rst_ni, (add_push || mid_push || final_push) |-> (!out_valid_q || out_o.ready), "result overwrites pending item")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ternary rule match table: adds and key lookups
// go in through a valid/ready channel with random gaps, a built-in table model
// predicts every reply, and each reply on the output channel is compared
// field by field while the receiver stalls at random
// ----------------------------------------------------------------------------
module tb_top;
  import trmt_pkg::*;

  localparam int TBL_DEPTH    = RULE_SLOTS_DEF;
  localparam int COND_BITS    = COND_WIDTH_DEF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam longint CYCLE_LIMIT = 6000000;

  logic clk_i = 1'b0;
  logic rst_ni;

  trmt_stream_if #(.payload_t(in_item_t))  in_if ();
  trmt_stream_if #(.payload_t(out_item_t)) out_if ();

  ternary_rule_match_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // table model
  logic [DATA_W-1:0] tbl_value  [TBL_DEPTH];
  logic [DATA_W-1:0] tbl_care   [TBL_DEPTH];
  int unsigned       tbl_length [TBL_DEPTH];
  int unsigned       tbl_count = 0;

  out_item_t       awaited_replies[$];
  int unsigned     error_count = 0;
  longint unsigned cycle_count = 0;
  bit              no_gaps = 1'b0;
  bit              hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned cap_len(int unsigned n);
    return (n > COND_BITS) ? COND_BITS : n;
  endfunction

  function automatic void predict_table_reply(in_item_t it);
    out_item_t         res;
    int unsigned       klen;
    int unsigned       limit;
    int unsigned       hits;
    logic [DATA_W-1:0] kmask;
    res = '0;
    res.last = 1'b1;
    if (it.op == OP_ADD) begin
      if (tbl_count < TBL_DEPTH) begin
        tbl_value[tbl_count]  = it.cond_value;
        tbl_care[tbl_count]   = it.cond_care;
        tbl_length[tbl_count] = cap_len(32'(it.cond_length));
        res.matched_index = IDX_OUT_W'(tbl_count);
        res.accepted = 1'b1;
        tbl_count++;
      end
      awaited_replies.push_back(res);
      return;
    end
    klen  = cap_len(32'(it.key_length));
    limit = (int'(it.match_limit) > TBL_DEPTH) ? TBL_DEPTH : int'(it.match_limit);
    kmask = (klen >= DATA_W) ? '1 : DATA_W'((64'd1 << klen) - 64'd1);
    hits  = 0;
    for (int i = 0; i < tbl_count && hits < limit; i++) begin
      if (tbl_length[i] >= klen &&
          ((tbl_value[i] ^ it.key_bits) & tbl_care[i] & kmask) == '0) begin
        res = '0;
        res.matched_index = IDX_OUT_W'(i);
        res.hit = 1'b1;
        awaited_replies.push_back(res);
        hits++;
      end
    end
    if (hits == 0) begin
      res = '0;
      res.last = 1'b1;
    end else begin
      res = awaited_replies.pop_back();
      res.last = 1'b1;
      res.match_count = CNT_OUT_W'(hits);
    end
    awaited_replies.push_back(res);
  endfunction

  function automatic void check_reply(out_item_t got);
    out_item_t want;
    if (awaited_replies.size() == 0) begin
      $error("reply with nothing pending: matched_index %0d hit %0b last %0b",
             got.matched_index, got.hit, got.last);
      error_count++;
      return;
    end
    want = awaited_replies.pop_front();
    if (got.matched_index !== want.matched_index) begin
      $error("matched_index: expected %0d, got %0d", want.matched_index, got.matched_index);
      error_count++;
    end
    if (got.hit !== want.hit) begin
      $error("hit: expected %0b, got %0b", want.hit, got.hit);
      error_count++;
    end
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
      error_count++;
    end
    if (got.match_count !== want.match_count) begin
      $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
      error_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      check_reply(out_if.payload);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : reply_sink
    int unsigned idle_left;
    int unsigned busy_left;
    int unsigned hold_left;
    idle_left = 0;
    busy_left = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (idle_left == 0 && busy_left == 0) begin
          busy_left = $urandom_range(1, 24);
          idle_left = gap_len();
        end
        if (idle_left > 0) begin
          idle_left--;
          out_if.ready <= 1'b0;
        end else begin
          busy_left--;
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    predict_table_reply(it);
  endtask

  function automatic in_item_t random_fields();
    in_item_t it;
    it.op          = $urandom_range(0, 1) ? OP_MATCH : OP_ADD;
    it.cond_value  = $urandom;
    it.cond_care   = $urandom;
    it.cond_length = LEN_IN_W'($urandom_range(0, 63));
    it.key_bits    = $urandom;
    it.key_length  = LEN_IN_W'($urandom_range(0, 63));
    it.match_limit = LIMIT_W'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] pick_care();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return $urandom;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 45) return LIMIT_W'($urandom_range(1, 4));
    if (roll < 80) return LIMIT_W'($urandom_range(5, TBL_DEPTH));
    return LIMIT_W'($urandom_range(TBL_DEPTH + 1, 127));
  endfunction

  function automatic in_item_t make_add();
    in_item_t it;
    it = random_fields();
    it.op = OP_ADD;
    it.cond_care = pick_care();
    if ($urandom_range(0, 9) < 7) it.cond_length = LEN_IN_W'($urandom_range(0, COND_BITS));
    return it;
  endfunction

  // mostly keys built to hit a stored rule, the rest random
  function automatic in_item_t make_match();
    in_item_t    it;
    int unsigned idx;
    it = random_fields();
    it.op = OP_MATCH;
    it.match_limit = pick_limit();
    if (tbl_count > 0 && $urandom_range(0, 9) < 7) begin
      idx = $urandom_range(0, tbl_count - 1);
      it.key_bits = (tbl_value[idx] & tbl_care[idx]) | (it.key_bits & ~tbl_care[idx]);
      if ($urandom_range(0, 7) == 0) it.key_bits ^= DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      it.key_length = LEN_IN_W'($urandom_range(0, tbl_length[idx]));
    end
    return it;
  endfunction

  task automatic add_rule(logic [DATA_W-1:0] value, logic [DATA_W-1:0] care,
                          logic [LEN_IN_W-1:0] len);
    in_item_t it;
    it = random_fields();
    it.op          = OP_ADD;
    it.cond_value  = value;
    it.cond_care   = care;
    it.cond_length = len;
    send_item(it);
  endtask

  task automatic match_key(logic [DATA_W-1:0] key, logic [LEN_IN_W-1:0] len,
                           logic [LIMIT_W-1:0] limit);
    in_item_t it;
    it = random_fields();
    it.op          = OP_MATCH;
    it.key_bits    = key;
    it.key_length  = len;
    it.match_limit = limit;
    send_item(it);
  endtask

  task automatic test_empty_table();
    match_key('1, 6'd63, 7'd127);
    match_key('0, 6'd0, 7'd1);
  endtask

  task automatic test_add_extremes();
    add_rule('1, '1, 6'd32);
    add_rule('0, '1, 6'd63);
    add_rule($urandom, '0, 6'd0);
    add_rule(32'h5555_5555, 32'hFFFF_0000, 6'd33);
    add_rule(32'hA5A5_00FF, 32'h0000_FFFF, 6'd16);
  endtask

  task automatic test_match_cases();
    // zero key length hits every rule
    match_key($urandom, 6'd0, 7'd127);
    match_key('1, 6'd32, 7'd64);
    // over-long key length
    match_key('0, 6'd63, 7'd127);
    match_key($urandom, 6'd16, 7'd0);
    match_key($urandom, 6'd0, 7'd1);
    match_key(32'h0000_00FF, 6'd16, 7'd3);
    // rule shorter than key
    match_key('0, 6'd17, 7'd127);
    match_key($urandom, LEN_IN_W'($urandom_range(0, 63)),
              LIMIT_W'($urandom_range(65, 127)));
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned add_pct);
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < add_pct) send_item(make_add());
      else send_item(make_match());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (20) begin
      if ($urandom_range(0, 99) < 30) send_item(make_add());
      else send_item(make_match());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_table_full();
    int extra;
    extra = TBL_DEPTH - int'(tbl_count);
    if (extra < 0) extra = 0;
    repeat (extra + 3) send_item(make_add());
    match_key($urandom, 6'd0, 7'd64);
    match_key($urandom, 6'd0, 7'd127);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_add_extremes();
    test_match_cases();
    test_random_traffic(200, 20);
    test_backpressure();
    test_table_full();
    test_random_traffic(220, 10);

    in_if.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/trmt_pkg.sv
rtl/core/trmt_stream_if.sv
rtl/core/trmt_ram.sv
rtl/core/ternary_rule_match_table.sv
tb/tb_top.sv
